FILE: sv/scanf_spec_parser_core_defines.svh
// assertion macros for the scanf specifier parser
`ifndef SCANF_SPEC_PARSER_CORE_DEFINES_SVH
`define SCANF_SPEC_PARSER_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SCANF_SPEC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define SCANF_SPEC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/scanf_spec_pkg.sv
package scanf_spec_pkg;

    // code units that steer the parse
    localparam logic [15:0] CU_STAR   = 16'h002A;
    localparam logic [15:0] CU_PAREN  = 16'h0028;
    localparam logic [15:0] CU_DOLLAR = 16'h0024;
    localparam logic [15:0] CU_ZERO   = 16'h0030;
    localparam logic [15:0] CU_H      = 16'h0068;
    localparam logic [15:0] CU_LOWL   = 16'h006C;
    localparam logic [15:0] CU_BIGL   = 16'h004C;
    localparam logic [15:0] CU_SPACE  = 16'h0020;

    // size modifier codes
    localparam logic [2:0] MOD_NONE  = 3'd0;
    localparam logic [2:0] MOD_SHORT = 3'd1;
    localparam logic [2:0] MOD_LONG  = 3'd2;
    localparam logic [2:0] MOD_LLONG = 3'd3;
    localparam logic [2:0] MOD_LDBL  = 3'd4;

    // number of hex pad digits after the parenthesis
    localparam logic [2:0] HEX_DIGITS = 3'd4;

    // absent position or width
    localparam logic signed [16:0] NUM_NONE = -17'sd1;

    localparam logic [15:0] SAT_MAX = 16'hFFFF;

    function automatic logic is_digit(input logic [15:0] u);
        return (u >= CU_ZERO) && (u <= CU_ZERO + 16'd9);
    endfunction

    // acc * 10 + digit, saturating at 65535
    function automatic logic [15:0] acc_digit(input logic [15:0] acc, input logic [15:0] u);
        logic [19:0] v;
        v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {16'd0, u[3:0]};
        return (v > {4'd0, SAT_MAX}) ? SAT_MAX : v[15:0];
    endfunction

    // hex digit value, all ones for anything else
    function automatic logic [15:0] hex_value(input logic [15:0] u);
        logic [15:0] r;
        if (u >= 16'h0030 && u <= 16'h0039) begin
            r = u - 16'h0030;
        end else if (u >= 16'h0061 && u <= 16'h0066) begin
            r = u - 16'h0057;
        end else if (u >= 16'h0041 && u <= 16'h0046) begin
            r = u - 16'h0037;
        end else begin
            r = 16'hFFFF;
        end
        return r;
    endfunction

endpackage

FILE: sv/scanf_spec_parser_core.sv
// channel | direction | handshake                  | payload
// --------+-----------+----------------------------+-------------------------------------
// in      | sink      | i_in_valid / o_in_ready    | i_code_unit
// out     | source    | o_out_valid / i_out_ready  | o_arg_position .. o_units_consumed
//
// one code unit a cycle while no letter waits on a stalled result; a unit passes an
// input register, then one step of the parse state machine (with a multiply-by-ten
// accumulate); a letter's result then goes into the result register and leaves from it
// synchronous active-low reset returns the parse to the leading percent, no sweep
// a stalled result holds only a letter behind it; other units keep flowing
`include "scanf_spec_parser_core_defines.svh"

module scanf_spec_parser_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [15:0]         i_code_unit,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [16:0]  o_arg_position,
    output logic                o_skip_argument,
    output logic [15:0]         o_pad_unit,
    output logic signed [16:0]  o_field_width,
    output logic [2:0]          o_size_modifier,
    output logic [15:0]         o_conversion_letter,
    output logic [15:0]         o_units_consumed
);
    import scanf_spec_pkg::*;

    typedef enum logic [2:0] {
        PH_PERCENT,
        PH_START,
        PH_ARGNUM,
        PH_FLAGS,
        PH_HEX,
        PH_WIDTH,
        PH_AFTER_L,
        PH_LETTER
    } t_phase;

    // input register
    logic               r_in_valid;
    logic [15:0]        r_in_unit;

    // parse state
    t_phase             r_phase,      n_phase;
    logic [15:0]        r_acc,        n_acc;
    logic signed [16:0] r_pos,        n_pos;
    logic               r_skip,       n_skip;
    logic [15:0]        r_pad,        n_pad;
    logic [2:0]         r_hex_count,  n_hex_count;
    logic signed [16:0] r_width,      n_width;
    logic [2:0]         r_mod,        n_mod;
    logic [15:0]        r_unit_count, n_unit_count;

    // result register
    logic               r_out_valid;
    logic signed [16:0] r_out_pos;
    logic               r_out_skip;
    logic [15:0]        r_out_pad;
    logic signed [16:0] r_out_width;
    logic [2:0]         r_out_mod;
    logic [15:0]        r_out_letter;
    logic [15:0]        r_out_count;

    logic emit;
    logic do_flag;
    logic do_mod;
    logic proc_go;
    logic in_take;

    // one parse step on the registered unit
    always_comb begin
        n_phase      = r_phase;
        n_acc        = r_acc;
        n_pos        = r_pos;
        n_skip       = r_skip;
        n_pad        = r_pad;
        n_hex_count  = r_hex_count;
        n_width      = r_width;
        n_mod        = r_mod;
        n_unit_count = (r_unit_count != SAT_MAX) ? r_unit_count + 16'd1 : r_unit_count;
        emit         = 1'b0;
        do_flag      = 1'b0;
        do_mod       = 1'b0;

        unique case (r_phase)
            PH_PERCENT: begin
                n_phase = PH_START;
            end
            PH_START: begin
                if (is_digit(r_in_unit)) begin
                    n_acc   = {12'd0, r_in_unit[3:0]};
                    n_phase = PH_ARGNUM;
                end else begin
                    do_flag = 1'b1;
                end
            end
            PH_ARGNUM: begin
                if (is_digit(r_in_unit)) begin
                    n_acc = acc_digit(r_acc, r_in_unit);
                end else if (r_in_unit == CU_DOLLAR) begin
                    n_pos   = signed'({1'b0, r_acc});
                    n_acc   = 16'd0;
                    n_phase = PH_FLAGS;
                end else begin
                    n_width = signed'({1'b0, r_acc});
                    n_acc   = 16'd0;
                    do_mod  = 1'b1;
                end
            end
            PH_FLAGS: begin
                do_flag = 1'b1;
            end
            PH_HEX: begin
                if (r_hex_count < HEX_DIGITS) begin
                    n_pad       = {r_pad[11:0], 4'h0} + hex_value(r_in_unit);
                    n_hex_count = r_hex_count + 3'd1;
                end else begin
                    n_hex_count = 3'd0;
                    n_phase     = PH_FLAGS;
                end
            end
            PH_WIDTH: begin
                if (is_digit(r_in_unit)) begin
                    n_acc = acc_digit(r_acc, r_in_unit);
                end else begin
                    n_width = signed'({1'b0, r_acc});
                    n_acc   = 16'd0;
                    do_mod  = 1'b1;
                end
            end
            PH_AFTER_L: begin
                if (r_in_unit == CU_LOWL) begin
                    n_mod   = MOD_LLONG;
                    n_phase = PH_LETTER;
                end else begin
                    n_mod = MOD_LONG;
                    emit  = 1'b1;
                end
            end
            PH_LETTER: begin
                emit = 1'b1;
            end
            default: begin
                emit = 1'b1;
            end
        endcase

        // flag, width start, or fall through to modifier
        if (do_flag) begin
            if (r_in_unit == CU_STAR) begin
                n_skip  = 1'b1;
                n_phase = PH_FLAGS;
            end else if (r_in_unit == CU_PAREN) begin
                n_hex_count = 3'd0;
                n_phase     = PH_HEX;
            end else if (is_digit(r_in_unit)) begin
                n_acc   = {12'd0, r_in_unit[3:0]};
                n_phase = PH_WIDTH;
            end else begin
                do_mod = 1'b1;
            end
        end

        // modifier or conversion letter
        if (do_mod) begin
            if (r_in_unit == CU_H) begin
                n_mod   = MOD_SHORT;
                n_phase = PH_LETTER;
            end else if (r_in_unit == CU_LOWL) begin
                n_phase = PH_AFTER_L;
            end else if (r_in_unit == CU_BIGL) begin
                n_mod   = MOD_LDBL;
                n_phase = PH_LETTER;
            end else begin
                emit = 1'b1;
            end
        end
    end

    // a beat moves on unless it is a letter facing a full, stalled result
    assign proc_go    = r_in_valid && (!emit || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || proc_go;
    assign in_take    = i_in_valid && o_in_ready;

    // state, input register and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_phase      <= PH_PERCENT;
            r_acc        <= 16'd0;
            r_pos        <= NUM_NONE;
            r_skip       <= 1'b0;
            r_pad        <= CU_SPACE;
            r_hex_count  <= 3'd0;
            r_width      <= NUM_NONE;
            r_mod        <= MOD_NONE;
            r_unit_count <= 16'd0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
                r_in_unit  <= i_code_unit;
            end else if (proc_go) begin
                r_in_valid <= 1'b0;
            end

            if (proc_go && emit) begin
                r_out_valid  <= 1'b1;
                r_out_pos    <= n_pos;
                r_out_skip   <= n_skip;
                r_out_pad    <= n_pad;
                r_out_width  <= n_width;
                r_out_mod    <= n_mod;
                r_out_letter <= r_in_unit;
                r_out_count  <= n_unit_count;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (proc_go) begin
                if (emit) begin
                    r_phase      <= PH_PERCENT;
                    r_acc        <= 16'd0;
                    r_pos        <= NUM_NONE;
                    r_skip       <= 1'b0;
                    r_pad        <= CU_SPACE;
                    r_hex_count  <= 3'd0;
                    r_width      <= NUM_NONE;
                    r_mod        <= MOD_NONE;
                    r_unit_count <= 16'd0;
                end else begin
                    r_phase      <= n_phase;
                    r_acc        <= n_acc;
                    r_pos        <= n_pos;
                    r_skip       <= n_skip;
                    r_pad        <= n_pad;
                    r_hex_count  <= n_hex_count;
                    r_width      <= n_width;
                    r_mod        <= n_mod;
                    r_unit_count <= n_unit_count;
                end
            end
        end
    end

    // result ports
    assign o_out_valid         = r_out_valid;
    assign o_arg_position      = r_out_pos;
    assign o_skip_argument     = r_out_skip;
    assign o_pad_unit          = r_out_pad;
    assign o_field_width       = r_out_width;
    assign o_size_modifier     = r_out_mod;
    assign o_conversion_letter = r_out_letter;
    assign o_units_consumed    = r_out_count;

    // checks
    `SCANF_SPEC_ASSERT_NOW(a_stall_only_on_letter, r_in_valid && !proc_go, emit && r_out_valid && !i_out_ready, "parse stalled without a blocked result")
    `SCANF_SPEC_ASSERT_NEXT(a_clear_after_emit, proc_go && emit, r_phase == PH_PERCENT && r_unit_count == 16'd0, "parse state not cleared after a result")
    `SCANF_SPEC_ASSERT_NOW(a_count_nonzero, o_out_valid, o_units_consumed != 16'd0, "result with zero units consumed")
    `SCANF_SPEC_ASSERT_NOW(a_hex_count_range, 1'b1, r_hex_count <= HEX_DIGITS, "hex digit count out of range")

endmodule

FILE: test/scanf_spec_parser_core_tb.sv
module scanf_spec_parser_core_tb;
    import scanf_spec_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 16;
    localparam logic [15:0] CU_PERCENT = 16'h0025;

    // parse position within one specifier
    typedef enum logic [2:0] {
        AT_PERCENT,
        AT_START,
        AT_POS_DIGITS,
        AT_FLAGS,
        AT_PAD_DIGITS,
        AT_WIDTH_DIGITS,
        AT_AFTER_LONG,
        AT_LETTER
    } t_parse_phase;

    typedef struct packed {
        logic signed [16:0] arg_position;
        logic               skip_argument;
        logic [15:0]        pad_unit;
        logic signed [16:0] field_width;
        logic [2:0]         size_modifier;
        logic [15:0]        conversion_letter;
        logic [15:0]        units_consumed;
    } t_spec_fields;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [15:0]        i_code_unit;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [16:0] o_arg_position;
    logic               o_skip_argument;
    logic [15:0]        o_pad_unit;
    logic signed [16:0] o_field_width;
    logic [2:0]         o_size_modifier;
    logic [15:0]        o_conversion_letter;
    logic [15:0]        o_units_consumed;

    // own copy of the parse state
    t_parse_phase       spec_phase;
    logic [15:0]        digit_acc;
    logic signed [16:0] spec_position;
    logic               spec_skip;
    logic [15:0]        spec_pad;
    logic [2:0]         pad_digit_count;
    logic signed [16:0] spec_width;
    logic [2:0]         spec_modifier;
    logic [15:0]        spec_unit_count;

    t_spec_fields expected_specs[$];
    logic [15:0]  pending_units[$];

    int send_idle_pct;
    int recv_stall_pct;
    int mismatch_count;
    int idle_cycles;
    int units_sent;

    scanf_spec_parser_core DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_code_unit         (i_code_unit),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_arg_position      (o_arg_position),
        .o_skip_argument     (o_skip_argument),
        .o_pad_unit          (o_pad_unit),
        .o_field_width       (o_field_width),
        .o_size_modifier     (o_size_modifier),
        .o_conversion_letter (o_conversion_letter),
        .o_units_consumed    (o_units_consumed)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic is_dec_digit(input logic [15:0] u);
        return (u >= CU_ZERO) && (u <= CU_ZERO + 16'd9);
    endfunction

    // decimal accumulate, clamped at the top of the 16-bit range
    function automatic logic [15:0] dec_accumulate(input logic [15:0] acc, input logic [15:0] u);
        int v;
        v = int'(acc) * 10 + int'(u - CU_ZERO);
        return (v > int'(SAT_MAX)) ? SAT_MAX : 16'(v);
    endfunction

    task automatic clear_spec_state();
        spec_phase      = AT_PERCENT;
        digit_acc       = 16'd0;
        spec_position   = NUM_NONE;
        spec_skip       = 1'b0;
        spec_pad        = CU_SPACE;
        pad_digit_count = 3'd0;
        spec_width      = NUM_NONE;
        spec_modifier   = MOD_NONE;
        spec_unit_count = 16'd0;
    endtask

    // conversion letter reached: queue the fields and start over
    task automatic close_spec(input logic [15:0] letter);
        t_spec_fields f;
        f.arg_position      = spec_position;
        f.skip_argument     = spec_skip;
        f.pad_unit          = spec_pad;
        f.field_width       = spec_width;
        f.size_modifier     = spec_modifier;
        f.conversion_letter = letter;
        f.units_consumed    = spec_unit_count;
        expected_specs.push_back(f);
        clear_spec_state();
    endtask

    task automatic modifier_or_letter(input logic [15:0] u);
        if (u == CU_H) begin
            spec_modifier = MOD_SHORT;
            spec_phase    = AT_LETTER;
        end else if (u == CU_LOWL) begin
            spec_phase = AT_AFTER_LONG;
        end else if (u == CU_BIGL) begin
            spec_modifier = MOD_LDBL;
            spec_phase    = AT_LETTER;
        end else begin
            close_spec(u);
        end
    endtask

    task automatic flag_width_or_rest(input logic [15:0] u);
        if (u == CU_STAR) begin
            spec_skip  = 1'b1;
            spec_phase = AT_FLAGS;
        end else if (u == CU_PAREN) begin
            pad_digit_count = 3'd0;
            spec_phase      = AT_PAD_DIGITS;
        end else if (is_dec_digit(u)) begin
            digit_acc  = u - CU_ZERO;
            spec_phase = AT_WIDTH_DIGITS;
        end else begin
            modifier_or_letter(u);
        end
    endtask

    // predicted effect of one accepted code unit
    task automatic parse_unit(input logic [15:0] u);
        logic [15:0] nibble;
        if (spec_unit_count != SAT_MAX) spec_unit_count = spec_unit_count + 16'd1;
        case (spec_phase)
            AT_PERCENT: begin
                spec_phase = AT_START;
            end
            AT_START: begin
                if (is_dec_digit(u)) begin
                    digit_acc  = u - CU_ZERO;
                    spec_phase = AT_POS_DIGITS;
                end else begin
                    flag_width_or_rest(u);
                end
            end
            AT_POS_DIGITS: begin
                if (is_dec_digit(u)) begin
                    digit_acc = dec_accumulate(digit_acc, u);
                end else if (u == CU_DOLLAR) begin
                    spec_position = {1'b0, digit_acc};
                    digit_acc     = 16'd0;
                    spec_phase    = AT_FLAGS;
                end else begin
                    // no dollar: the digits were the width
                    spec_width = {1'b0, digit_acc};
                    digit_acc  = 16'd0;
                    modifier_or_letter(u);
                end
            end
            AT_FLAGS: begin
                flag_width_or_rest(u);
            end
            AT_PAD_DIGITS: begin
                if (pad_digit_count < HEX_DIGITS) begin
                    // 0-9, a-f, A-F; anything else adds all ones
                    if (u >= 16'h0030 && u <= 16'h0039) nibble = u - 16'h0030;
                    else if (u >= 16'h0061 && u <= 16'h0066) nibble = u - 16'h0061 + 16'd10;
                    else if (u >= 16'h0041 && u <= 16'h0046) nibble = u - 16'h0041 + 16'd10;
                    else nibble = 16'hFFFF;
                    spec_pad        = (spec_pad << 4) + nibble;
                    pad_digit_count = pad_digit_count + 3'd1;
                end else begin
                    pad_digit_count = 3'd0;
                    spec_phase      = AT_FLAGS;
                end
            end
            AT_WIDTH_DIGITS: begin
                if (is_dec_digit(u)) begin
                    digit_acc = dec_accumulate(digit_acc, u);
                end else begin
                    spec_width = {1'b0, digit_acc};
                    digit_acc  = 16'd0;
                    modifier_or_letter(u);
                end
            end
            AT_AFTER_LONG: begin
                if (u == CU_LOWL) begin
                    spec_modifier = MOD_LLONG;
                    spec_phase    = AT_LETTER;
                end else begin
                    spec_modifier = MOD_LONG;
                    close_spec(u);
                end
            end
            default: begin
                close_spec(u);
            end
        endcase
    endtask

    // one input beat, with random idle cycles ahead of it
    task automatic send_unit(input logic [15:0] u);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_code_unit <= u;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        parse_unit(u);
        units_sent++;
    endtask

    task automatic send_pending();
        while (pending_units.size() != 0) send_unit(pending_units.pop_front());
    endtask

    // result side: random stalls, each accepted beat checked against the oldest prediction
    initial begin
        t_spec_fields exp_f;
        t_spec_fields got_f;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                got_f = '{o_arg_position, o_skip_argument, o_pad_unit, o_field_width,
                          o_size_modifier, o_conversion_letter, o_units_consumed};
                if (expected_specs.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: pos=%0d skip=%0b pad=%h wid=%0d mod=%0d let=%h n=%0d",
                                 got_f.arg_position, got_f.skip_argument, got_f.pad_unit,
                                 got_f.field_width, got_f.size_modifier,
                                 got_f.conversion_letter, got_f.units_consumed);
                end else begin
                    exp_f = expected_specs.pop_front();
                    if (got_f.arg_position !== exp_f.arg_position ||
                        got_f.skip_argument !== exp_f.skip_argument ||
                        got_f.pad_unit !== exp_f.pad_unit ||
                        got_f.field_width !== exp_f.field_width ||
                        got_f.size_modifier !== exp_f.size_modifier ||
                        got_f.conversion_letter !== exp_f.conversion_letter ||
                        got_f.units_consumed !== exp_f.units_consumed) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("mismatch exp: pos=%0d skip=%0b pad=%h wid=%0d mod=%0d let=%h n=%0d",
                                     exp_f.arg_position, exp_f.skip_argument, exp_f.pad_unit,
                                     exp_f.field_width, exp_f.size_modifier,
                                     exp_f.conversion_letter, exp_f.units_consumed);
                            $display("         got: pos=%0d skip=%0b pad=%h wid=%0d mod=%0d let=%h n=%0d",
                                     got_f.arg_position, got_f.skip_argument, got_f.pad_unit,
                                     got_f.field_width, got_f.size_modifier,
                                     got_f.conversion_letter, got_f.units_consumed);
                        end
                    end
                end
            end
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog on cycles with no beat on either side
    initial begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("scanf_spec_parser_core_tb NOT OK");
        $finish;
    end

    // extreme leading unit and the smallest letter, nothing between
    task automatic test_bare_letter();
        send_unit(16'hFFFF);
        send_unit(16'h0000);
    endtask

    // position, skip, width through the flag stage, long
    task automatic test_position_and_flags();
        pending_units = '{CU_PERCENT, CU_ZERO + 16'd1, CU_ZERO + 16'd2, CU_DOLLAR, CU_STAR,
                          CU_ZERO + 16'd5, CU_LOWL, {8'h00, "d"}};
        send_pending();
    endtask

    // pad digits with a non-hex unit, short, digit taken as the letter
    task automatic test_pad_digits();
        pending_units = '{CU_PERCENT, CU_PAREN, {8'h00, "a"}, CU_ZERO, {8'h00, "F"},
                          {8'h00, "z"}, {8'h00, "!"}, CU_H, CU_ZERO + 16'd9};
        send_pending();
    endtask

    // digits without dollar become the width, then long long
    task automatic test_width_without_dollar();
        pending_units = '{CU_PERCENT, CU_ZERO + 16'd3, CU_ZERO + 16'd4, CU_LOWL, CU_LOWL,
                          {8'h00, "u"}};
        send_pending();
    endtask

    // clamped width, long double, dollar taken as the letter
    task automatic test_number_saturation();
        pending_units.push_back(CU_PERCENT);
        repeat (6) pending_units.push_back(CU_ZERO + 16'd7);
        pending_units.push_back(CU_BIGL);
        pending_units.push_back(CU_DOLLAR);
        send_pending();
    endtask

    // a long run of skip flags before the letter
    task automatic test_long_specifier();
        send_unit(CU_PERCENT);
        repeat (40) send_unit(CU_STAR);
        send_unit({8'h00, "d"});
    endtask

    task automatic push_digits();
        int n;
        n = ($urandom_range(9) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 3);
        repeat (n) pending_units.push_back(CU_ZERO + 16'($urandom_range(9)));
    endtask

    // mostly well-formed specifiers with random content, some noise and broken ones
    task automatic queue_random_spec();
        int kind;
        int r;
        kind = $urandom_range(99);
        if (kind < 12) begin
            repeat ($urandom_range(1, 6)) pending_units.push_back(16'($urandom));
        end else begin
            pending_units.push_back((kind < 18) ? 16'($urandom) : CU_PERCENT);
            if ($urandom_range(2) == 0) begin
                push_digits();
                if ($urandom_range(7) != 0) pending_units.push_back(CU_DOLLAR);
            end
            repeat ($urandom_range(0, 3)) begin
                if ($urandom_range(1) == 0) begin
                    pending_units.push_back(CU_STAR);
                end else begin
                    pending_units.push_back(CU_PAREN);
                    repeat (4) begin
                        r = $urandom_range(21);
                        if ($urandom_range(4) == 0) pending_units.push_back(16'($urandom));
                        else if (r < 10) pending_units.push_back(16'h0030 + 16'(r));
                        else if (r < 16) pending_units.push_back(16'h0061 + 16'(r - 10));
                        else pending_units.push_back(16'h0041 + 16'(r - 16));
                    end
                    pending_units.push_back(16'($urandom));
                end
            end
            if ($urandom_range(1) == 0) push_digits();
            case ($urandom_range(5))
                0: pending_units.push_back(CU_H);
                1: pending_units.push_back(CU_LOWL);
                2: begin
                    pending_units.push_back(CU_LOWL);
                    pending_units.push_back(CU_LOWL);
                end
                3: pending_units.push_back(CU_BIGL);
                default: ;
            endcase
            // letter: mostly lower case, sometimes any unit, sometimes missing
            r = $urandom_range(9);
            if (r < 6) pending_units.push_back(16'h0061 + 16'($urandom_range(25)));
            else if (r < 9) pending_units.push_back(16'($urandom));
        end
    endtask

    task automatic test_random_stream(input int idle_pct, input int stall_pct, input int n_units);
        int start_count;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        start_count    = units_sent;
        while (units_sent - start_count < n_units) begin
            queue_random_spec();
            send_pending();
        end
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_code_unit    <= 16'd0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mismatch_count = 0;
        units_sent     = 0;
        clear_spec_state();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_bare_letter();
        test_position_and_flags();
        test_pad_digits();
        test_width_without_dollar();
        test_number_saturation();
        test_long_specifier();

        test_random_stream(0, 0, 160);
        test_random_stream(74, 0, 160);
        test_random_stream(0, 74, 160);
        test_random_stream(33, 33, 170);

        // drain and let any late result show up
        i_in_valid <= 1'b0;
        while (expected_specs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("scanf_spec_parser_core_tb OK");
        end else begin
            $display("scanf_spec_parser_core_tb NOT OK");
        end
        $finish;
    end

endmodule
